// ===== design/bounded_deque_with_indexed_access_core_assert.svh =====
// assertion macros used by the checker in bdq_checker.sv
`ifndef BOUNDED_DEQUE_WITH_INDEXED_ACCESS_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_INDEXED_ACCESS_CORE_ASSERT_SVH

// clocked assertion, quiet while reset is held
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bdq_pkg.sv =====
`timescale 1ns / 1ps
package bdq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    // fixed port widths
    localparam int ACT_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    // circular slot at distance off from base, off <= DEPTH
    function automatic addr_t slot_of(input addr_t base, input cnt_t off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
            sum = sum - SUM_W'(DEPTH);
        return ADDR_W'(sum);
    endfunction

endpackage

// ===== design/bdq_ram.sv =====
`timescale 1ns / 1ps
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bounded_deque_with_indexed_access_core.sv =====
// bounded double-ended queue with indexed read and remove
// input channel: in_valid / in_stall carry action, value and position; a
// transaction completes on a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall carry value_out, status and count,
// exactly one result per input transaction, in order.
// each request waits in the response state until the output register is
// free, and the registered read of the entry store lands in it from there;
// no new push, pop, read or remove is taken while in the response state.
// a remove in the middle then shifts the later entries one slot a cycle
// through the store in the shift state; in_stall stays high until it ends.
// otherwise in_stall drops once the previous transaction's result sits
// in the output register, so a new request can be taken while it waits.
// when the receiver stalls, the output holds; a second result waits inside
// and in_stall stays high until the output register frees up.
// reset empties the queue and the output; the entry store is not cleared,
// since no entry is read before it has been written.
`timescale 1ns / 1ps
module bounded_deque_with_indexed_access_core
    import bdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACT_W-1:0]    action,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [VALUE_W-1:0]  value_out,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  count
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RESP  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]          state_reg, state_next;
    addr_t               front_reg, front_next;
    cnt_t                cnt_reg, cnt_next;
    cnt_t                k_reg, k_next;
    cnt_t                pos_reg, pos_next;
    logic [STATUS_W-1:0] req_status_reg, req_status_next;
    logic                req_data_reg, req_data_next;
    logic                req_shift_reg, req_shift_next;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_out_reg;
    logic [STATUS_W-1:0] status_reg;
    cnt_t                count_reg;

    logic  out_free;
    logic  out_load;
    logic  ram_we, ram_re;
    addr_t ram_waddr, ram_raddr;
    data_t ram_wdata, ram_rdata;

    logic [CMP_W-1:0] pos_x, cnt_x;
    logic             full, empty;

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign pos_x = CMP_W'(position);
    assign cnt_x = CMP_W'(cnt_reg);
    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        req_status_next = req_status_reg;
        req_data_next   = req_data_reg;
        req_shift_next  = req_shift_reg;
        out_load        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = front_reg;
        ram_wdata       = DATA_WIDTH'(value);
        ram_re          = 1'b0;
        ram_raddr       = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next      = S_RESP;
                    pos_next        = CNT_W'(position);
                    req_status_next = ST_OK;
                    req_data_next   = 1'b0;
                    req_shift_next  = 1'b0;
                    unique case (action)
                        ACT_PUSH_FRONT:
                        begin
                            if (full)
                                req_status_next = ST_FULL;
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_of(front_reg, CNT_W'(DEPTH - 1));
                                front_next = ram_waddr;
                                cnt_next   = cnt_reg + CNT_W'(1);
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (full)
                                req_status_next = ST_FULL;
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_of(front_reg, cnt_reg);
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (empty)
                                req_status_next = ST_EMPTY;
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = front_reg;
                                req_data_next = 1'b1;
                                front_next    = slot_of(front_reg, CNT_W'(1));
                                cnt_next      = cnt_reg - CNT_W'(1);
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (empty)
                                req_status_next = ST_EMPTY;
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = slot_of(front_reg, cnt_reg - CNT_W'(1));
                                req_data_next = 1'b1;
                                cnt_next      = cnt_reg - CNT_W'(1);
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_x >= cnt_x)
                                req_status_next = ST_EMPTY;
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = slot_of(front_reg, CNT_W'(position));
                                req_data_next = 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (empty)
                                req_status_next = ST_EMPTY;
                            else if (position == '0)
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = front_reg;
                                req_data_next = 1'b1;
                                front_next    = slot_of(front_reg, CNT_W'(1));
                                cnt_next      = cnt_reg - CNT_W'(1);
                            end
                            else if (pos_x + CMP_W'(1) >= cnt_x)
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = slot_of(front_reg, cnt_reg - CNT_W'(1));
                                req_data_next = 1'b1;
                                cnt_next      = cnt_reg - CNT_W'(1);
                            end
                            else
                            begin
                                // middle entry: later entries move up afterwards
                                ram_re         = 1'b1;
                                ram_raddr      = slot_of(front_reg, CNT_W'(position));
                                req_data_next  = 1'b1;
                                req_shift_next = 1'b1;
                                cnt_next       = cnt_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            req_status_next = ST_EMPTY;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (req_shift_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot_of(front_reg, pos_reg + CNT_W'(1));
                        k_next     = pos_reg;
                        state_next = S_SHIFT;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // entry k+1 arrives from the store and lands in slot k
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_reg, k_reg);
                ram_wdata = ram_rdata;
                k_next    = k_reg + CNT_W'(1);
                if (k_reg + CNT_W'(1) < cnt_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot_of(front_reg, k_reg + CNT_W'(2));
                end
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            req_status_reg <= ST_OK;
            req_data_reg   <= 1'b0;
            req_shift_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            req_status_reg <= req_status_next;
            req_data_reg   <= req_data_next;
            req_shift_reg  <= req_shift_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (out_load)
        begin
            value_out_reg <= req_data_reg ? VALUE_W'(ram_rdata) : '0;
            status_reg    <= req_status_reg;
            count_reg     <= cnt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign count     = COUNT_W'(count_reg);

endmodule

// ===== design/bdq_checker.sv =====
`timescale 1ns / 1ps
`include "bounded_deque_with_indexed_access_core_assert.svh"
module bdq_checker
    import bdq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [VALUE_W-1:0]  value_out,
    input logic [STATUS_W-1:0] status,
    input logic [COUNT_W-1:0]  count
);

    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(DEPTH);

    logic held;
    logic failed;
    logic refused;

    assign held    = out_valid && out_stall;
    assign failed  = out_valid && (status != ST_OK);
    assign refused = out_valid && (status == ST_FULL);

    `BDQ_ASSERT(a_out_hold, held |=> out_valid, "result dropped while stalled")
    `BDQ_ASSERT(a_out_stable, held |=> $stable({value_out, status, count}), "stalled result changed")
    `BDQ_ASSERT(a_zero_on_error, failed |-> value_out == '0, "data on a failed transaction")
    `BDQ_ASSERT(a_full_count, refused |-> count == COUNT_CAP, "push refused below capacity")
    `BDQ_ASSERT_ALWAYS(a_count_range, out_valid |-> count <= COUNT_CAP, "count past capacity")

endmodule

bind bounded_deque_with_indexed_access_core bdq_checker u_bdq_checker (.*);

// ===== test/bounded_deque_with_indexed_access_core_checker.sv =====
`timescale 1ns / 1ps
module bounded_deque_with_indexed_access_core_checker
    import bdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [ACT_W-1:0]    action,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [VALUE_W-1:0]  value_out,
    input  logic [STATUS_W-1:0] status,
    input  logic [COUNT_W-1:0]  count,
    output int                  fail_count,
    output int                  pending
);

    typedef struct {
        logic [VALUE_W-1:0]  word;
        logic [STATUS_W-1:0] code;
        logic [COUNT_W-1:0]  held;
    } deque_result_t;

    // shadow copy of the circular store
    data_t slots [DEPTH];
    int    head;
    int    fill;
    int    mismatches;
    int    results_seen;

    deque_result_t expected_results [$];

    function automatic data_t take_front();
        data_t w;
        w    = slots[head];
        head = (head + 1) % DEPTH;
        fill--;
        return w;
    endfunction

    function automatic data_t take_back();
        data_t w;
        w = slots[(head + fill - 1) % DEPTH];
        fill--;
        return w;
    endfunction

    function automatic deque_result_t next_deque_result(
        input logic [ACT_W-1:0]   act,
        input logic [VALUE_W-1:0] val,
        input logic [POS_W-1:0]   pos
    );
        deque_result_t r;
        data_t         w;
        int            idx;
        w      = '0;
        r.code = ST_OK;
        idx    = int'(pos);
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (fill >= DEPTH)
                    r.code = ST_FULL;
                else if (act == ACT_PUSH_FRONT)
                begin
                    head        = (head + DEPTH - 1) % DEPTH;
                    slots[head] = data_t'(val);
                    fill++;
                end
                else
                begin
                    slots[(head + fill) % DEPTH] = data_t'(val);
                    fill++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (fill == 0)
                    r.code = ST_EMPTY;
                else if (act == ACT_POP_FRONT)
                    w = take_front();
                else
                    w = take_back();
            end
            ACT_READ:
            begin
                if (idx >= fill)
                    r.code = ST_EMPTY;
                else
                    w = slots[(head + idx) % DEPTH];
            end
            ACT_REMOVE:
            begin
                if (fill == 0)
                    r.code = ST_EMPTY;
                else if (idx == 0)
                    w = take_front();
                else if (idx >= fill - 1)
                    w = take_back();
                else
                begin
                    // close the gap, later entries move one toward the front
                    w = slots[(head + idx) % DEPTH];
                    for (int k = idx; k + 1 < fill; k++)
                        slots[(head + k) % DEPTH] = slots[(head + k + 1) % DEPTH];
                    fill--;
                end
            end
            default:
                r.code = ST_EMPTY;
        endcase
        r.word = VALUE_W'(w);
        r.held = COUNT_W'(fill);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t want;
        if (!rst_n)
        begin
            head         = 0;
            fill         = 0;
            mismatches   = 0;
            results_seen = 0;
            expected_results.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // check the outgoing transaction first so an early result is not masked
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: result %0d arrived with none expected: %h %0d %0d",
                                 results_seen, value_out, status, count);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (value_out !== want.word || status !== want.code
                        || count !== want.held)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"checker: result %0d mismatch: expected value %h ",
                                      "status %0d count %0d, got value %h status %0d count %0d"},
                                     results_seen, want.word, want.code, want.held,
                                     value_out, status, count);
                    end
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
                expected_results.push_back(next_deque_result(action, value, position));
            pending    <= expected_results.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== test/bounded_deque_with_indexed_access_core_tb.sv =====
`timescale 1ns / 1ps
module bounded_deque_with_indexed_access_core_tb;
    import bdq_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [ACT_W-1:0]    action    = '0;
    logic [VALUE_W-1:0]  value     = '0;
    logic [POS_W-1:0]    position  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [VALUE_W-1:0]  value_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    int fail_count;
    int pending;

    bit hold_request;
    bit burst;
    bit tx_quiet;
    int tx_mode_left;

    bounded_deque_with_indexed_access_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value_out (value_out),
        .status    (status),
        .count     (count)
    );

    bounded_deque_with_indexed_access_core_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_out  (value_out),
        .status     (status),
        .count      (count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic send_request(
        input logic [ACT_W-1:0]   act,
        input logic [VALUE_W-1:0] val,
        input logic [POS_W-1:0]   pos
    );
        int gap;
        if (tx_mode_left == 0)
        begin
            tx_quiet     = ($urandom_range(0, 2) == 0);
            tx_mode_left = $urandom_range(15, 50);
        end
        tx_mode_left--;
        gap = (burst || tx_quiet) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= val;
        position <= pos;
        do @(posedge clk); while (in_stall);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        int mode_left;
        bit quiet;
        mode_left = 0;
        quiet     = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                out_stall <= 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    quiet     = ($urandom_range(0, 2) == 0);
                    mode_left = $urandom_range(15, 50);
                end
                mode_left--;
                n = quiet ? 0 : $urandom_range(0, 14);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int r;
        int phase_left;
        int push_pct;
        int pop_pct;
        int read_pct;
        logic [ACT_W-1:0] act;
        phase_left   = 0;
        push_pct     = 0;
        pop_pct      = 0;
        read_pct     = 0;
        tx_mode_left = 0;
        burst        = 0;
        hold_request = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store and unused codes
        send_request(ACT_POP_FRONT, '0, '0);
        send_request(ACT_POP_BACK, '0, '0);
        send_request(ACT_REMOVE, '0, '0);
        send_request(ACT_READ, '0, '0);
        send_request(ACT_SPARE_LO, 32'hFFFF_FFFF, 4'hF);
        send_request(ACT_SPARE_HI, 32'hFFFF_FFFF, 4'hF);
        // front pop that leaves one entry, which must survive as the back
        send_request(ACT_PUSH_BACK, 32'h0000_0000, '0);
        send_request(ACT_PUSH_FRONT, 32'hFFFF_FFFF, '0);
        send_request(ACT_POP_FRONT, '0, '0);
        send_request(ACT_READ, '0, 4'd0);
        send_request(ACT_POP_BACK, '0, '0);
        // indexed read and remove at front, middle and past the back
        send_request(ACT_PUSH_BACK, 32'h0000_0001, '0);
        send_request(ACT_PUSH_BACK, 32'h0000_0002, '0);
        send_request(ACT_PUSH_BACK, 32'h0000_0003, '0);
        send_request(ACT_PUSH_FRONT, 32'hA5A5_5A5A, '0);
        send_request(ACT_READ, '0, 4'd15);
        send_request(ACT_READ, '0, 4'd3);
        send_request(ACT_REMOVE, '0, 4'd2);
        send_request(ACT_REMOVE, '0, 4'd15);
        send_request(ACT_REMOVE, '0, 4'd0);
        send_request(ACT_REMOVE, '0, 4'd1);
        send_request(ACT_POP_BACK, '0, '0);

        // back-to-back pushes against a long receiver hold: fills the store too
        hold_request = 1;
        burst        = 1;
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom(), '0);
        burst = 0;
        send_request(ACT_READ, '0, 4'd0);
        send_request(ACT_READ, '0, 4'd15);
        send_request(ACT_REMOVE, '0, 4'd7);

        // random phases leaning toward filling, draining or a mix
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_pct = 60; pop_pct = 10; read_pct = 15;
                    end
                    1:
                    begin
                        push_pct = 10; pop_pct = 40; read_pct = 15;
                    end
                    default:
                    begin
                        push_pct = 35; pop_pct = 25; read_pct = 20;
                    end
                endcase
            end
            phase_left--;
            r = $urandom_range(0, 99);
            if (r < 3)
                act = r[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
                else if (r < push_pct + pop_pct)
                    act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
                else if (r < push_pct + pop_pct + read_pct)
                    act = ACT_READ;
                else
                    act = ACT_REMOVE;
            end
            send_request(act, $urandom(), POS_W'($urandom_range(0, 15)));
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
